// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define SWTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define SWTC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/swtc_pkg.sv -----
// Package with the time type, operation codes and digit helpers of the stopwatch.
package swtc_pkg;

    localparam logic [9:0] MS_MAX       = 10'd999;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [3:0] SEC_TENS_MAX = 4'd5;

    typedef enum logic [2:0] {
        FUNC_MS_UP    = 3'd0,
        FUNC_MS_DOWN  = 3'd1,
        FUNC_SEC_UP   = 3'd2,
        FUNC_SEC_DOWN = 3'd3,
        FUNC_DIG_UP   = 3'd4,
        FUNC_DIG_DOWN = 3'd5,
        FUNC_READ     = 3'd6,
        FUNC_SPARE    = 3'd7    // spare code, acts like a plain read
    } t_func;

    typedef enum logic [1:0] {
        SEL_SEC_ONES = 2'd0,
        SEL_SEC_TENS = 2'd1,
        SEL_MIN_ONES = 2'd2,
        SEL_MIN_TENS = 2'd3
    } t_sel;

    typedef struct packed {
        logic [9:0] millis;
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
    } t_time;

    // Raise a digit, wrap past top to zero.
    function automatic logic [3:0] digit_up(input logic [3:0] d, input logic [3:0] top);
        return (d >= top) ? 4'd0 : d + 4'd1;
    endfunction

    // Lower a digit, wrap below zero to top.
    function automatic logic [3:0] digit_down(input logic [3:0] d, input logic [3:0] top);
        return (d == 4'd0) ? top : d - 4'd1;
    endfunction

endpackage

// ----- design/swtc_step.sv -----
// Next-time logic for one stopwatch operation.
module swtc_step
    import swtc_pkg::*;
(
    input  t_time      i_cur,
    input  logic [2:0] i_func,
    input  logic [1:0] i_sel,
    output t_time      o_nxt
);

    logic  sec_inc;
    logic  sec_dec;
    logic  edit_up;
    t_time tmp;

    always_comb begin
        tmp     = i_cur;
        sec_inc = 1'b0;
        sec_dec = 1'b0;
        edit_up = (i_func == FUNC_DIG_UP);
        case (t_func'(i_func))
            FUNC_MS_UP: begin
                if (i_cur.millis >= MS_MAX) begin
                    tmp.millis = 10'd0;
                    sec_inc    = 1'b1;
                end else begin
                    tmp.millis = i_cur.millis + 10'd1;
                end
            end
            FUNC_MS_DOWN: begin
                if (i_cur.millis == 10'd0) begin
                    tmp.millis = MS_MAX;
                    sec_dec    = 1'b1;
                end else begin
                    tmp.millis = i_cur.millis - 10'd1;
                end
            end
            FUNC_SEC_UP:   sec_inc = 1'b1;
            FUNC_SEC_DOWN: sec_dec = 1'b1;
            FUNC_DIG_UP, FUNC_DIG_DOWN: begin
                // Edit one digit only, no carry into its neighbor.
                case (t_sel'(i_sel))
                    SEL_SEC_ONES: tmp.sec_ones = edit_up
                        ? digit_up(i_cur.sec_ones, DIGIT_MAX)
                        : digit_down(i_cur.sec_ones, DIGIT_MAX);
                    SEL_SEC_TENS: tmp.sec_tens = edit_up
                        ? 3'(digit_up({1'b0, i_cur.sec_tens}, SEC_TENS_MAX))
                        : 3'(digit_down({1'b0, i_cur.sec_tens}, SEC_TENS_MAX));
                    SEL_MIN_ONES: tmp.min_ones = edit_up
                        ? digit_up(i_cur.min_ones, DIGIT_MAX)
                        : digit_down(i_cur.min_ones, DIGIT_MAX);
                    SEL_MIN_TENS: tmp.min_tens = edit_up
                        ? digit_up(i_cur.min_tens, DIGIT_MAX)
                        : digit_down(i_cur.min_tens, DIGIT_MAX);
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Ripple a one-second step through the digit chain.
        if (sec_inc) begin
            tmp.sec_ones = digit_up(i_cur.sec_ones, DIGIT_MAX);
            if (i_cur.sec_ones >= DIGIT_MAX) begin
                tmp.sec_tens = 3'(digit_up({1'b0, i_cur.sec_tens}, SEC_TENS_MAX));
                if ({1'b0, i_cur.sec_tens} >= SEC_TENS_MAX) begin
                    tmp.min_ones = digit_up(i_cur.min_ones, DIGIT_MAX);
                    if (i_cur.min_ones >= DIGIT_MAX) begin
                        tmp.min_tens = digit_up(i_cur.min_tens, DIGIT_MAX);
                    end
                end
            end
        end else if (sec_dec) begin
            tmp.sec_ones = digit_down(i_cur.sec_ones, DIGIT_MAX);
            if (i_cur.sec_ones == 4'd0) begin
                tmp.sec_tens = 3'(digit_down({1'b0, i_cur.sec_tens}, SEC_TENS_MAX));
                if (i_cur.sec_tens == 3'd0) begin
                    tmp.min_ones = digit_down(i_cur.min_ones, DIGIT_MAX);
                    if (i_cur.min_ones == 4'd0) begin
                        tmp.min_tens = digit_down(i_cur.min_tens, DIGIT_MAX);
                    end
                end
            end
        end
        o_nxt = tmp;
    end

endmodule

// ----- design/stopwatch_time_counter.sv -----
// Top level of the stopwatch time counter: handshake, time register and result port.
//
//  channel  | dir | tdata fields, lowest bit up
//  ---------+-----+--------------------------------------------------------------
//  s (cmd)  | in  | func[2:0], digit_sel[4:3], zero pad [7:5]
//  m (time) | out | sec_ones[3:0], sec_tens[6:4], min_ones[10:7], min_tens[14:11],
//           |     | millis[24:15], zero pad [31:25]
//
// An accepted command updates the time register at the same clock edge, and the
// result is valid from the next cycle on. A new command is taken every cycle
// while the downstream side takes results.
// Reset (synchronous, active low) clears the time to 00:00.000 and the result slot.
// While a result stalls, hold it and hold off commands; a command is still taken in
// the cycle the waiting result is transferred.
//
// Digits are BCD and millis binary, so the result register is the time register.
module stopwatch_time_counter
    import swtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // func[2:0], digit_sel[4:3]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // sec_ones, sec_tens, min_ones, min_tens, millis
);

    t_time r_time;
    t_time n_time;
    logic  r_out_valid;
    logic  s_xfer;

    // Slot is free when empty or being drained this cycle.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    swtc_step u_step (
        .i_cur  (r_time),
        .i_func (i_s_tdata[2:0]),
        .i_sel  (i_s_tdata[4:3]),
        .o_nxt  (n_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_time <= n_time;
            end
            // Advance the result slot: fill on a command, drop on a transfer out.
            if (s_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_time.millis, r_time.min_tens, r_time.min_ones,
                         r_time.sec_tens, r_time.sec_ones};

endmodule

// ----- design/swtc_checker.sv -----
// Port-level checker for the stopwatch time counter, bound to the top level.
`include "assert_macros.svh"

module swtc_checker
    import swtc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic digits_ok;
    logic read_xfer;

    assign digits_ok = (o_m_tdata[3:0] <= DIGIT_MAX)
                    && (o_m_tdata[6:4] <= SEC_TENS_MAX[2:0])
                    && (o_m_tdata[10:7] <= DIGIT_MAX)
                    && (o_m_tdata[14:11] <= DIGIT_MAX)
                    && (o_m_tdata[24:15] <= MS_MAX)
                    && (o_m_tdata[31:25] == 7'd0);
    assign read_xfer = i_s_tvalid && o_s_tready
                    && ((i_s_tdata[2:0] == FUNC_READ) || (i_s_tdata[2:0] == FUNC_SPARE));

    `SWTC_ASSERT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    `SWTC_ASSERT(a_ready_rule, i_clk, i_rst_n, o_s_tready == (!o_m_tvalid || i_m_tready), "command ready does not follow the result slot")
    `SWTC_ASSERT(a_digit_range, i_clk, i_rst_n, o_m_tvalid |-> digits_ok, "time digit out of range")
    `SWTC_ASSERT(a_read_keeps, i_clk, i_rst_n, read_xfer |=> o_m_tvalid && $stable(o_m_tdata), "read command changed the time")

endmodule

bind stopwatch_time_counter swtc_checker u_swtc_checker (.*);

// ----- tb/stopwatch_time_counter_test.sv -----
// Self-checking testbench for the stopwatch time counter: command stream in, time stream out.
`timescale 1ns / 100ps

module stopwatch_time_counter_test;
    import swtc_pkg::*;

    localparam int SEC_LAST = 59;
    localparam int MIN_LAST = 99;
    localparam int MS_LAST  = 999;
    localparam int SHOW_MAX = 10;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;   // func[2:0], digit_sel[4:3], zero pad [7:5]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;           // sec_ones, sec_tens, min_ones, min_tens, millis, pad

    stopwatch_time_counter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Percent of cycles in which each side holds off
    int cmd_idle_pct  = 10;
    int time_idle_pct = 78;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= time_idle_pct);
    end

    // Time kept by the predictor
    logic [6:0] pred_min = 7'd0;
    logic [5:0] pred_sec = 6'd0;
    logic [9:0] pred_ms  = 10'd0;

    t_time time_q[$];   // expected times, oldest first
    int    n_fail = 0;

    // Directed command currently on the bus, with its hand-written time if any
    bit    cmd_typed = 1'b0;
    t_time cmd_want  = '0;

    typedef struct {
        logic [2:0] func;
        logic [1:0] sel;
        bit         typed;
        t_time      want;
    } cmd_row_t;

    cmd_row_t plan[$];

    function automatic t_time time_of(input int mins, input int secs, input int ms);
        t_time r;
        r.sec_ones = 4'(secs % 10);
        r.sec_tens = 3'(secs / 10);
        r.min_ones = 4'(mins % 10);
        r.min_tens = 4'(mins / 10);
        r.millis   = 10'(ms);
        return r;
    endfunction

    // Raise or lower one digit of a two-digit value, no carry out of it
    function automatic int edit_digit(input int v, input bit on_tens, input bit up,
                                      input int tens_top);
        int ones;
        int tens;
        ones = v % 10;
        tens = v / 10;
        if (on_tens) begin
            if (up) tens = (tens >= tens_top) ? 0 : tens + 1;
            else    tens = (tens == 0) ? tens_top : tens - 1;
        end else begin
            if (up) ones = (ones >= 9) ? 0 : ones + 1;
            else    ones = (ones == 0) ? 9 : ones - 1;
        end
        return tens * 10 + ones;
    endfunction

    task automatic sec_fwd();
        if (int'(pred_sec) >= SEC_LAST) begin
            pred_sec = 6'd0;
            pred_min = (int'(pred_min) >= MIN_LAST) ? 7'd0 : pred_min + 7'd1;
        end else begin
            pred_sec = pred_sec + 6'd1;
        end
    endtask

    task automatic sec_back();
        if (pred_sec == 6'd0) begin
            pred_sec = 6'(SEC_LAST);
            pred_min = (pred_min == 7'd0) ? 7'(MIN_LAST) : pred_min - 7'd1;
        end else begin
            pred_sec = pred_sec - 6'd1;
        end
    endtask

    // Apply one command to the predicted time
    task automatic step_clock(input logic [2:0] func, input logic [1:0] sel);
        case (func)
            FUNC_MS_UP: begin
                if (int'(pred_ms) >= MS_LAST) begin
                    pred_ms = 10'd0;
                    sec_fwd();
                end else begin
                    pred_ms = pred_ms + 10'd1;
                end
            end
            FUNC_MS_DOWN: begin
                if (pred_ms == 10'd0) begin
                    pred_ms = MS_MAX;
                    sec_back();
                end else begin
                    pred_ms = pred_ms - 10'd1;
                end
            end
            FUNC_SEC_UP:   sec_fwd();
            FUNC_SEC_DOWN: sec_back();
            FUNC_DIG_UP, FUNC_DIG_DOWN: begin
                if (sel == SEL_SEC_ONES || sel == SEL_SEC_TENS)
                    pred_sec = 6'(edit_digit(int'(pred_sec), sel == SEL_SEC_TENS,
                                             func == FUNC_DIG_UP, int'(SEC_TENS_MAX)));
                else
                    pred_min = 7'(edit_digit(int'(pred_min), sel == SEL_MIN_TENS,
                                             func == FUNC_DIG_UP, int'(DIGIT_MAX)));
            end
            default: ;
        endcase
    endtask

    task automatic note_fail(input string what, input t_time want, input logic [31:0] got);
        t_time g;
        g = got[24:0];
        if (n_fail < SHOW_MAX)
            $display("%0t %s: want %0d%0d:%0d%0d.%0d got %0d%0d:%0d%0d.%0d pad %0h", $realtime,
                     what, want.min_tens, want.min_ones, want.sec_tens, want.sec_ones,
                     want.millis, g.min_tens, g.min_ones, g.sec_tens, g.sec_ones, g.millis,
                     got[31:25]);
        n_fail++;
    endtask

    // Check transfers on the time side, then predict for the command side
    t_time want_now;
    t_time got_now;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_now = o_m_tdata[24:0];
                if (time_q.size() == 0) begin
                    note_fail("unexpected time", '0, o_m_tdata);
                end else begin
                    want_now = time_q.pop_front();
                    if (got_now.sec_ones !== want_now.sec_ones ||
                        got_now.sec_tens !== want_now.sec_tens ||
                        got_now.min_ones !== want_now.min_ones ||
                        got_now.min_tens !== want_now.min_tens ||
                        got_now.millis   !== want_now.millis   ||
                        o_m_tdata[31:25] !== 7'd0)
                        note_fail("time mismatch", want_now, o_m_tdata);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                step_clock(i_s_tdata[2:0], i_s_tdata[4:3]);
                if (cmd_typed) time_q.push_back(cmd_want);
                else time_q.push_back(time_of(int'(pred_min), int'(pred_sec), int'(pred_ms)));
            end
        end
    end

    // Present one command and hold it until transferred
    task automatic send_cmd(input logic [2:0] func, input logic [1:0] sel,
                            input bit typed, input t_time want);
        while ($urandom_range(99) < cmd_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, sel, func};
        cmd_typed  = typed;
        cmd_want   = want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop valid and wait until every expected time has come back
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (time_q.size() != 0) @(posedge i_clk);
    endtask

    // Random commands, with bursts of millisecond ticks to cross second boundaries
    task automatic run_random(input int count);
        int left;
        int burst;
        logic [2:0] tick;
        left = count;
        while (left > 0) begin
            if ($urandom_range(15) == 0) begin
                burst = $urandom_range(40, 8);
                tick  = $urandom_range(1) ? FUNC_MS_UP : FUNC_MS_DOWN;
                repeat (burst) send_cmd(tick, 2'($urandom_range(3)), 1'b0, '0);
                left -= burst;
            end else begin
                send_cmd(3'($urandom_range(7)), 2'($urandom_range(3)), 1'b0, '0);
                left--;
            end
        end
    endtask

    task automatic add_row(input logic [2:0] func, input logic [1:0] sel,
                           input bit typed, input t_time want);
        cmd_row_t r;
        r.func  = func;
        r.sel   = sel;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endtask

    initial begin
        // Reset state, spare code, then borrow and carry through the minute wrap
        add_row(FUNC_READ,     SEL_SEC_ONES, 1'b1, time_of(0, 0, 0));
        add_row(FUNC_SPARE,    SEL_MIN_TENS, 1'b1, time_of(0, 0, 0));
        add_row(FUNC_MS_DOWN,  SEL_SEC_ONES, 1'b1, time_of(MIN_LAST, SEC_LAST, MS_LAST));
        add_row(FUNC_MS_UP,    SEL_MIN_TENS, 1'b1, time_of(0, 0, 0));
        add_row(FUNC_SEC_DOWN, SEL_SEC_TENS, 1'b1, time_of(MIN_LAST, SEC_LAST, 0));
        add_row(FUNC_READ,     SEL_MIN_ONES, 1'b1, time_of(MIN_LAST, SEC_LAST, 0));
        add_row(FUNC_SEC_UP,   SEL_MIN_ONES, 1'b1, time_of(0, 0, 0));
        add_row(FUNC_MS_DOWN,  SEL_MIN_TENS, 1'b1, time_of(MIN_LAST, SEC_LAST, MS_LAST));
        // Digit edits from the top of every digit, each wrapping on its own; then ms and sec steps and the spare code
        add_row(FUNC_DIG_UP,   SEL_MIN_TENS, 1'b0, '0);
        add_row(FUNC_DIG_UP,   SEL_MIN_ONES, 1'b0, '0);
        add_row(FUNC_DIG_UP,   SEL_SEC_TENS, 1'b0, '0);
        add_row(FUNC_DIG_UP,   SEL_SEC_ONES, 1'b0, '0);
        add_row(FUNC_DIG_DOWN, SEL_SEC_ONES, 1'b0, '0);
        add_row(FUNC_DIG_DOWN, SEL_SEC_TENS, 1'b0, '0);
        add_row(FUNC_DIG_DOWN, SEL_MIN_ONES, 1'b0, '0);
        add_row(FUNC_DIG_DOWN, SEL_MIN_TENS, 1'b0, '0);
        add_row(FUNC_MS_UP,    SEL_SEC_TENS, 1'b0, '0);
        add_row(FUNC_MS_UP,    SEL_MIN_ONES, 1'b0, '0);
        add_row(FUNC_SEC_DOWN, SEL_MIN_TENS, 1'b0, '0);
        add_row(FUNC_SPARE,    SEL_SEC_ONES, 1'b0, '0);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_cmd(plan[k].func, plan[k].sel, plan[k].typed, plan[k].want);
        run_random(300);
        drain();

        cmd_idle_pct  = 78;
        time_idle_pct = 10;
        run_random(310);
        drain();

        cmd_idle_pct  = 0;
        time_idle_pct = 0;
        run_random(320);
        drain();

        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
